/* sv/gcpc_pkg.sv */
// gcpc_pkg: shared types, codes and constant tables for the graph-cut capacity block.
// No dependencies; imported by every module of the block.
package gcpc_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_NSCALE = 3'd2;
  localparam logic [2:0] REG_INV2S2 = 3'd3;
  localparam logic [2:0] REG_TSCALE = 3'd4;

  localparam logic [10:0] WidthRst  = 11'd1024;
  localparam logic [10:0] HeightRst = 11'd1024;
  localparam logic [15:0] NScaleRst = 16'd100;
  localparam logic [31:0] Inv2S2Rst = 32'd83886;
  localparam logic [15:0] TScaleRst = 16'd256;

  // result slots of one input word
  localparam logic [1:0] SLOT_ABOVE = 2'd0;  // pixel of the previous row
  localparam logic [1:0] SLOT_LEFT  = 2'd1;  // last row, previous column
  localparam logic [1:0] SLOT_LAST  = 2'd2;  // last pixel of the frame

  // neighbour directions
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_W = 2'd2;
  localparam logic [1:0] DIR_E = 2'd3;

  // line store read groups
  localparam logic [1:0] RD_CENTER = 2'd0;
  localparam logic [1:0] RD_SIDE   = 2'd1;
  localparam logic [1:0] RD_FAR    = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       exp_start;
    logic       zero_cap;
    logic       store_cap;
    logic [1:0] slot;
    logic [1:0] dir;
    logic       term_look;
    logic       term_mul;
    logic       load_out;
    logic       advance;
  } gcpc_cmd_t;

  typedef struct packed {
    logic [2:0] slot_act;
    logic       dir_en;
    logic       exp_done;
    logic       out_free;
  } gcpc_sts_t;

  // floor(2^32 / k)
  function automatic logic [32:0] recip_q32(input logic [4:0] k);
    logic [32:0] r;
    unique case (k)
      5'd1:    r = 33'd4294967296;
      5'd2:    r = 33'd2147483648;
      5'd3:    r = 33'd1431655765;
      5'd4:    r = 33'd1073741824;
      5'd5:    r = 33'd858993459;
      5'd6:    r = 33'd715827882;
      5'd7:    r = 33'd613566756;
      5'd8:    r = 33'd536870912;
      5'd9:    r = 33'd477218588;
      5'd10:   r = 33'd429496729;
      5'd11:   r = 33'd390451572;
      5'd12:   r = 33'd357913941;
      5'd13:   r = 33'd330382099;
      5'd14:   r = 33'd306783378;
      5'd15:   r = 33'd286331153;
      5'd16:   r = 33'd268435456;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

  // exp(-1) by the truncated 16-term series in Q.30
  function automatic logic [31:0] exp1_q30();
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] q;
    int k;
    pos  = 64'd1 << 30;
    neg  = 64'd0;
    term = 64'd1 << 30;
    for (k = 1; k <= 16; k++) begin
      q = (term * 64'(recip_q32(5'(k)))) >> 32;
      if (term - q * 64'(k) >= 64'(k)) q = q + 64'd1;
      term = q;
      if ((k & 1) != 0) neg = neg + q;
      else pos = pos + q;
    end
    return 32'((pos >= neg) ? pos - neg : 64'd0);
  endfunction

  // -ln(v/255) in Q4.12, epsilon-clamped at both ends
  function automatic logic [15:0] neg_ln_q12(input logic [7:0] v);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] total;
    int e;
    int i;
    if (v == 8'd0) return 16'd56588;
    if (v == 8'd255) return 16'd0;
    e = 0;
    for (i = 0; i < 8; i++) begin
      if ((64'(v) << (e + 1)) <= 64'd255) e = e + 1;
    end
    den = 64'(v) << e;
    num = 64'd255 << 30;
    rem = 64'd0;
    y   = 64'd0;
    for (i = 37; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        y   = y | (64'd1 << i);
      end
    end
    frac = 64'd0;
    for (i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y    = y >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    total = (64'(e) << 30) | frac;
    return 16'((total * 64'd744261118 + (64'd1 << 47)) >> 48);
  endfunction

  typedef logic [255:0][15:0] term_tab_t;

  function automatic term_tab_t build_term_tab();
    term_tab_t t;
    int i;
    for (i = 0; i < 256; i++) t[i] = neg_ln_q12(8'(i));
    return t;
  endfunction

  localparam logic [31:0] E1Q30   = exp1_q30();
  localparam term_tab_t   TermTab = build_term_tab();

endpackage

/* sv/gcpc_exp.sv */
// gcpc_exp: iterative neighbour capacity unit, floor(H * exp(-d^2 * k)).
// Depends on gcpc_pkg (reciprocal table, exp(-1) constant).
module gcpc_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  a_i,
  input  logic [7:0]  b_i,
  input  logic [31:0] inv2s2_i,
  input  logic [15:0] nscale_i,
  output logic        done_o,
  output logic [15:0] cap_o
);
  import gcpc_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE, E_SQ, E_MULK, E_CHK, E_MT, E_DV, E_CR, E_SUB, E_POW, E_RND, E_SCL, E_DONE
  } exp_state_e;

  exp_state_e  state_q;
  logic [7:0]  d_q;
  logic [15:0] dsq_q;
  logic [47:0] x_q;
  logic [3:0]  n_q;
  logic [23:0] h_q;
  logic [4:0]  k_q;
  logic [30:0] term_q;
  logic [54:0] prod_q;
  logic [29:0] v_q;
  logic [29:0] qe_q;
  logic [31:0] pos_q;
  logic [31:0] neg_q;
  logic [31:0] r_q;
  logic [18:0] e_q;
  logic [15:0] cap_q;

  logic [29:0] v_d;
  logic [62:0] qprod;
  logic [34:0] qk;
  logic [29:0] rem;
  logic [29:0] q_d;
  logic [62:0] pow_d;
  logic [32:0] rnd_d;
  logic [34:0] scl_d;

  always_comb begin
    v_d   = prod_q[53:24];
    qprod = 63'(v_d) * 63'(recip_q32(k_q));
    qk    = 35'(qe_q) * 35'(k_q);
    rem   = v_q - qk[29:0];
    q_d   = (rem >= 30'(k_q)) ? qe_q + 30'd1 : qe_q;
    pow_d = 63'(r_q) * 63'(E1Q30) + (63'd1 << 29);
    rnd_d = 33'(r_q) + 33'd8192;
    scl_d = 35'(nscale_i) * 35'(e_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            d_q     <= (a_i > b_i) ? a_i - b_i : b_i - a_i;
            state_q <= E_SQ;
          end
        end
        E_SQ: begin
          dsq_q   <= 16'(d_q) * 16'(d_q);
          state_q <= E_MULK;
        end
        E_MULK: begin
          x_q     <= 48'(dsq_q) * 48'(inv2s2_i);
          state_q <= E_CHK;
        end
        E_CHK: begin
          if (x_q[47:28] != 20'd0) begin
            e_q     <= 19'd0;
            state_q <= E_SCL;
          end else begin
            term_q  <= 31'd1 << 30;
            pos_q   <= 32'd1 << 30;
            neg_q   <= 32'd0;
            k_q     <= 5'd1;
            n_q     <= x_q[27:24];
            h_q     <= x_q[23:0];
            state_q <= E_MT;
          end
        end
        E_MT: begin
          prod_q  <= 55'(term_q) * 55'(h_q);
          state_q <= E_DV;
        end
        E_DV: begin
          v_q     <= v_d;
          qe_q    <= qprod[61:32];
          state_q <= E_CR;
        end
        E_CR: begin
          term_q <= 31'(q_d);
          if (k_q[0]) neg_q <= neg_q + 32'(q_d);
          else pos_q <= pos_q + 32'(q_d);
          if (k_q == 5'd16) begin
            state_q <= E_SUB;
          end else begin
            k_q     <= k_q + 5'd1;
            state_q <= E_MT;
          end
        end
        E_SUB: begin
          r_q     <= (pos_q >= neg_q) ? pos_q - neg_q : 32'd0;
          state_q <= (n_q == 4'd0) ? E_RND : E_POW;
        end
        E_POW: begin
          r_q <= pow_d[61:30];
          n_q <= n_q - 4'd1;
          if (n_q == 4'd1) state_q <= E_RND;
        end
        E_RND: begin
          e_q     <= rnd_d[32:14];
          state_q <= E_SCL;
        end
        E_SCL: begin
          cap_q   <= scl_d[31:16];
          state_q <= E_DONE;
        end
        E_DONE: state_q <= E_IDLE;
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == E_DONE);
  assign cap_o  = cap_q;

endmodule

/* sv/gcpc_datapath.sv */
// gcpc_datapath: line stores, frame counters, operand selection, terminal caps, output word.
// Depends on gcpc_pkg and gcpc_exp.
module gcpc_datapath #(
  parameter int unsigned MaxWidth  = gcpc_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = gcpc_pkg::MaxHeightDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gcpc_pkg::gcpc_cmd_t                cmd_i,
  output gcpc_pkg::gcpc_sts_t                sts_o,
  input  logic [7:0]                         intensity_i,
  input  logic                               restart_i,
  input  logic [$clog2(MaxWidth+1)-1:0]      width_i,
  input  logic [$clog2(MaxHeight+1)-1:0]     height_i,
  input  logic [15:0]                        nscale_i,
  input  logic [31:0]                        inv2s2_i,
  input  logic [15:0]                        tscale_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [9:0]                         row_o,
  output logic [9:0]                         col_o,
  output logic [15:0]                        cap_north_o,
  output logic [15:0]                        cap_south_o,
  output logic [15:0]                        cap_west_o,
  output logic [15:0]                        cap_east_o,
  output logic [11:0]                        cap_source_o,
  output logic [11:0]                        cap_sink_o,
  output logic                               last_of_run_o,
  output logic                               end_of_image_o
);
  import gcpc_pkg::*;

  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned RW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;

  logic [7:0]    older_mem [MaxWidth];
  logic [7:0]    newer_mem [MaxWidth];
  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [7:0]    prev_q;
  logic [7:0]    x_q;
  logic [7:0]    nrd_q, ord_q;
  logic [1:0]    rsel_q;
  logic          rvld_q;
  logic [7:0]    nc_q, oc_q, ncp1_q, ocm1_q, ncm2_q;
  logic [15:0]   caps_q [4];
  logic [15:0]   tsrc_q, tsnk_q;
  logic [11:0]   csrc_q, csnk_q;
  logic          out_valid_q;

  logic [AW-1:0] naddr, oaddr;
  logic [31:0]   c32, r32, w32, h32;
  logic          last_row, act0, act1, act2;
  logic [7:0]    center, nbr;
  logic          dir_en;
  logic          exp_done;
  logic [15:0]   exp_cap;
  logic [32:0]   psrc, psnk;
  logic [31:0]   row_sel, col_sel;
  logic          last_sel;

  assign c32      = 32'(col_q);
  assign r32      = 32'(row_q);
  assign w32      = 32'(width_i);
  assign h32      = 32'(height_i);
  assign last_row = (r32 + 32'd1 == h32);
  assign act0     = (r32 >= 32'd1);
  assign act1     = last_row && (c32 >= 32'd1);
  assign act2     = last_row && (c32 + 32'd1 == w32);

  // line store addresses
  always_comb begin
    case (cmd_i.rd_sel)
      RD_CENTER: naddr = col_q;
      RD_SIDE:   naddr = col_q + AW'(1);
      default:   naddr = col_q - AW'(2);
    endcase
    oaddr = (cmd_i.rd_sel == RD_SIDE) ? col_q - AW'(1) : col_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      nrd_q <= newer_mem[naddr];
      ord_q <= older_mem[oaddr];
    end
    if (cmd_i.wr_en) begin
      older_mem[col_q] <= nc_q;
      newer_mem[col_q] <= x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
      rsel_q <= RD_CENTER;
    end else begin
      rvld_q <= cmd_i.rd_en;
      rsel_q <= cmd_i.rd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) x_q <= intensity_i;
    if (rvld_q) begin
      case (rsel_q)
        RD_CENTER: begin
          nc_q <= nrd_q;
          oc_q <= ord_q;
        end
        RD_SIDE: begin
          ncp1_q <= nrd_q;
          ocm1_q <= ord_q;
        end
        default: ncm2_q <= nrd_q;
      endcase
    end
  end

  // frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      prev_q <= 8'd0;
    end else if (restart_i) begin
      col_q  <= '0;
      row_q  <= '0;
      prev_q <= 8'd0;
    end else if (cmd_i.advance) begin
      prev_q <= x_q;
      if (c32 + 32'd1 >= w32) begin
        col_q <= '0;
        row_q <= (r32 + 32'd1 >= h32) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // operand selection per slot and direction
  always_comb begin
    nbr    = x_q;
    dir_en = 1'b0;
    case (cmd_i.slot)
      SLOT_ABOVE: begin
        center = nc_q;
        case (cmd_i.dir)
          DIR_N: begin
            nbr    = oc_q;
            dir_en = (r32 >= 32'd2);
          end
          DIR_S: begin
            nbr    = x_q;
            dir_en = 1'b1;
          end
          DIR_W: begin
            nbr    = ocm1_q;
            dir_en = (c32 >= 32'd1);
          end
          default: begin
            nbr    = ncp1_q;
            dir_en = (c32 + 32'd1 < w32);
          end
        endcase
      end
      SLOT_LEFT: begin
        center = prev_q;
        case (cmd_i.dir)
          DIR_N: begin
            nbr    = ocm1_q;
            dir_en = (r32 >= 32'd1);
          end
          DIR_S:   dir_en = 1'b0;
          DIR_W: begin
            nbr    = ncm2_q;
            dir_en = (c32 >= 32'd2);
          end
          default: begin
            nbr    = x_q;
            dir_en = 1'b1;
          end
        endcase
      end
      default: begin
        center = x_q;
        case (cmd_i.dir)
          DIR_N: begin
            nbr    = nc_q;
            dir_en = (r32 >= 32'd1);
          end
          DIR_W: begin
            nbr    = prev_q;
            dir_en = (c32 >= 32'd1);
          end
          default: dir_en = 1'b0;
        endcase
      end
    endcase
  end

  gcpc_exp u_exp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.exp_start),
    .a_i      (center),
    .b_i      (nbr),
    .inv2s2_i (inv2s2_i),
    .nscale_i (nscale_i),
    .done_o   (exp_done),
    .cap_o    (exp_cap)
  );

  // terminal caps: table lookup, then alpha scaling with half-up rounding
  assign psrc = 33'(tscale_i) * 33'(tsrc_q) + (33'd1 << 19);
  assign psnk = 33'(tscale_i) * 33'(tsnk_q) + (33'd1 << 19);

  always_ff @(posedge clk_i) begin
    if (cmd_i.zero_cap) caps_q[cmd_i.dir] <= 16'd0;
    if (cmd_i.store_cap) caps_q[cmd_i.dir] <= exp_cap;
    if (cmd_i.term_look) begin
      tsrc_q <= TermTab[8'd255 - center];
      tsnk_q <= TermTab[center];
    end
    if (cmd_i.term_mul) begin
      csrc_q <= (psrc[32:20] == 13'd0 && tscale_i != 16'd0) ? 12'd1 : psrc[31:20];
      csnk_q <= (psnk[32:20] == 13'd0 && tscale_i != 16'd0) ? 12'd1 : psnk[31:20];
    end
  end

  // result position
  always_comb begin
    case (cmd_i.slot)
      SLOT_ABOVE: begin
        row_sel  = r32 - 32'd1;
        col_sel  = c32;
        last_sel = !act1 && !act2;
      end
      SLOT_LEFT: begin
        row_sel  = r32;
        col_sel  = c32 - 32'd1;
        last_sel = !act2;
      end
      default: begin
        row_sel  = r32;
        col_sel  = c32;
        last_sel = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      row_o          <= row_sel[9:0];
      col_o          <= col_sel[9:0];
      cap_north_o    <= caps_q[DIR_N];
      cap_south_o    <= caps_q[DIR_S];
      cap_west_o     <= caps_q[DIR_W];
      cap_east_o     <= caps_q[DIR_E];
      cap_source_o   <= csrc_q;
      cap_sink_o     <= csnk_q;
      last_of_run_o  <= last_sel;
      end_of_image_o <= (cmd_i.slot == SLOT_LAST);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.slot_act  = {act2, act1, act0};
  assign sts_o.dir_en    = dir_en;
  assign sts_o.exp_done  = exp_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

/* sv/gcpc_ctrl.sv */
// gcpc_ctrl: sequencer for one input word: line store reads/writes, result slots, caps.
// Depends on gcpc_pkg.
module gcpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gcpc_pkg::gcpc_sts_t sts_i,
  output gcpc_pkg::gcpc_cmd_t cmd_o
);
  import gcpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_WR, S_SLOT, S_CSTART, S_CWAIT,
    S_TLOOK, S_TMUL, S_EMIT, S_ADV
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic [1:0]  slot_q;
  logic [1:0]  dir_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.slot   = slot_q;
    cmd_o.dir    = dir_q;
    cmd_o.rd_sel = RD_CENTER;
    unique case (state_q)
      S_IDLE:   cmd_o.capture = in_valid_i;
      S_RD0:    cmd_o.rd_en = 1'b1;
      S_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SIDE;
      end
      S_RD2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_FAR;
      end
      S_WR:     cmd_o.wr_en = 1'b1;
      S_CSTART: begin
        cmd_o.exp_start = sts_i.dir_en;
        cmd_o.zero_cap  = !sts_i.dir_en;
      end
      S_CWAIT:  cmd_o.store_cap = sts_i.exp_done;
      S_TLOOK:  cmd_o.term_look = 1'b1;
      S_TMUL:   cmd_o.term_mul = 1'b1;
      S_EMIT:   cmd_o.load_out = sts_i.out_free;
      S_ADV:    cmd_o.advance = 1'b1;
      default:  cmd_o.capture = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= SLOT_ABOVE;
      dir_q   <= DIR_N;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_RD0;
        S_RD0:  state_q <= S_RD1;
        S_RD1:  state_q <= S_RD2;
        S_RD2:  state_q <= S_WR;
        S_WR: begin
          slot_q  <= SLOT_ABOVE;
          state_q <= S_SLOT;
        end
        S_SLOT: begin
          if (sts_i.slot_act[slot_q]) begin
            dir_q   <= DIR_N;
            state_q <= S_CSTART;
          end else if (slot_q == SLOT_LAST) begin
            state_q <= S_ADV;
          end else begin
            slot_q <= slot_q + 2'd1;
          end
        end
        S_CSTART: begin
          if (sts_i.dir_en) begin
            state_q <= S_CWAIT;
          end else if (dir_q == DIR_E) begin
            state_q <= S_TLOOK;
          end else begin
            dir_q <= dir_q + 2'd1;
          end
        end
        S_CWAIT: begin
          if (sts_i.exp_done) begin
            if (dir_q == DIR_E) begin
              state_q <= S_TLOOK;
            end else begin
              dir_q   <= dir_q + 2'd1;
              state_q <= S_CSTART;
            end
          end
        end
        S_TLOOK: state_q <= S_TMUL;
        S_TMUL:  state_q <= S_EMIT;
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (slot_q == SLOT_LAST) begin
              state_q <= S_ADV;
            end else begin
              slot_q  <= slot_q + 2'd1;
              state_q <= S_SLOT;
            end
          end
        end
        S_ADV:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/graph_cut_pixel_capacities_top.sv */
// graph_cut_pixel_capacities_top: graph-cut edge and terminal capacities for a raster stream.
// Depends on gcpc_pkg, gcpc_ctrl, gcpc_datapath (which holds gcpc_exp).
//
//  channel | dir | handshake                 | word
//  --------+-----+---------------------------+-------------------------------------------
//  in      | in  | in_valid_i / in_stall_o   | intensity_i
//  out     | out | out_valid_o / out_stall_i | row, col, 4 neighbour caps, source, sink,
//          |     |                           | last_of_run, end_of_image
//  cfg     | in  | APB psel/penable/pwrite   | 5 registers at byte address 4*index
//
// Sequence: one input word passes capture, line store reads and write, three slot checks and
// the counter step, plus per result it causes (0 to 3) terminal lookup, scaling and output
// load, and a zero capacity for each neighbour off the image.
// A neighbour on the image runs the shared exp unit: series terms, one multiply by exp(-1)
// per whole unit of d^2*k; once d^2*k >= 16 the series is skipped and the capacity is zero.
// Reset clears counters and control; the line stores are not cleared.
// The output register frees the sequencer: a new word is taken while a result waits.
module graph_cut_pixel_capacities_top #(
  parameter int unsigned MaxWidth  = gcpc_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = gcpc_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  intensity_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  row_o,
  output logic [9:0]  col_o,
  output logic [15:0] cap_north_o,
  output logic [15:0] cap_south_o,
  output logic [15:0] cap_west_o,
  output logic [15:0] cap_east_o,
  output logic [11:0] cap_source_o,
  output logic [11:0] cap_sink_o,
  output logic        last_of_run_o,
  output logic        end_of_image_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gcpc_pkg::*;

  localparam int unsigned WDW = $clog2(MaxWidth + 1);
  localparam int unsigned HDW = $clog2(MaxHeight + 1);

  logic [10:0] width_q;
  logic [10:0] height_q;
  logic [15:0] nscale_q;
  logic [31:0] inv2s2_q;
  logic [15:0] tscale_q;
  logic        wr_en;
  logic        restart;
  logic [31:0] w32, h32;
  logic [WDW-1:0] width_eff;
  logic [HDW-1:0] height_eff;
  gcpc_cmd_t   cmd;
  gcpc_sts_t   sts;

  // register write on the access phase
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && (paddr[4:2] == REG_WIDTH || paddr[4:2] == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      nscale_q <= NScaleRst;
      inv2s2_q <= Inv2S2Rst;
      tscale_q <= TScaleRst;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_WIDTH:  width_q  <= pwdata[10:0];
        REG_HEIGHT: height_q <= pwdata[10:0];
        REG_NSCALE: nscale_q <= pwdata[15:0];
        REG_INV2S2: inv2s2_q <= pwdata;
        REG_TSCALE: tscale_q <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_NSCALE: prdata = 32'(nscale_q);
      REG_INV2S2: prdata = inv2s2_q;
      REG_TSCALE: prdata = 32'(tscale_q);
      default:    prdata = 32'd0;
    endcase
  end

  // frame size as used: zero reads as one, large values saturate at the store size
  assign w32 = 32'(width_q);
  assign h32 = 32'(height_q);
  assign width_eff  = WDW'((w32 == 32'd0) ? 32'd1 :
                           ((w32 > 32'(MaxWidth)) ? 32'(MaxWidth) : w32));
  assign height_eff = HDW'((h32 == 32'd0) ? 32'd1 :
                           ((h32 > 32'(MaxHeight)) ? 32'(MaxHeight) : h32));

  gcpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gcpc_datapath #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .intensity_i    (intensity_i),
    .restart_i      (restart),
    .width_i        (width_eff),
    .height_i       (height_eff),
    .nscale_i       (nscale_q),
    .inv2s2_i       (inv2s2_q),
    .tscale_i       (tscale_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_o          (row_o),
    .col_o          (col_o),
    .cap_north_o    (cap_north_o),
    .cap_south_o    (cap_south_o),
    .cap_west_o     (cap_west_o),
    .cap_east_o     (cap_east_o),
    .cap_source_o   (cap_source_o),
    .cap_sink_o     (cap_sink_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

  // a taken word always occupies the sequencer for the next cycle
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer took a word but did not go busy");

  // the frame's last pixel is always the final result of its word
  a_eoi_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_image_o |-> last_of_run_o)
    else $error("end of image without last of run");

  // last pixel has no south or east neighbour
  a_eoi_edges : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_image_o |-> cap_south_o == 16'd0 && cap_east_o == 16'd0)
    else $error("end of image with nonzero south or east cap");

  // column always inside the frame
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(col_o) < 32'(width_eff))
    else $error("result column outside frame width");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// testbench: checks graph_cut_pixel_capacities_top against its own capacity predictor.
// Depends on gcpc_pkg and the RTL of the block; directed frames first, then random frames.
module testbench;
  import gcpc_pkg::*;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [15:0] north;
    logic [15:0] south;
    logic [15:0] west;
    logic [15:0] east;
    logic [11:0] source;
    logic [11:0] sink;
    logic        last_of_run;
    logic        end_of_image;
  } cap_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  intensity_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  cap_word_t   got;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [10:0] width_reg, height_reg;
  logic [15:0] nscale_reg, tscale_reg;
  logic [31:0] inv_reg;
  logic [7:0]  older_line [1024];
  logic [7:0]  newer_line [1024];
  int unsigned row_cnt, col_cnt;
  logic [7:0]  prev_pix;

  cap_word_t   pending_caps [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rand_items = 0;

  graph_cut_pixel_capacities_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .intensity_i,
    .out_valid_o, .out_stall_i,
    .row_o(got.row), .col_o(got.col),
    .cap_north_o(got.north), .cap_south_o(got.south),
    .cap_west_o(got.west), .cap_east_o(got.east),
    .cap_source_o(got.source), .cap_sink_o(got.sink),
    .last_of_run_o(got.last_of_run), .end_of_image_o(got.end_of_image),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------- predictor ----------------

  function automatic logic [63:0] exp_series(input logic [63:0] h);
    logic [63:0] pos, neg, term;
    pos  = 64'd1 << 30;
    neg  = 64'd0;
    term = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * h) >> 24) / 64'(k);
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    return (pos >= neg) ? pos - neg : 64'd0;
  endfunction

  function automatic logic [63:0] similarity(input logic [63:0] x);
    logic [63:0] r, e1, n;
    if (x >= (64'd16 << 24)) return 64'd0;
    n  = x >> 24;
    r  = exp_series(x & 64'hFFFFFF);
    e1 = exp_series(64'd1 << 24);
    for (int i = 0; i < int'(n); i++) r = (r * e1 + (64'd1 << 29)) >> 30;
    return (r + 64'd8192) >> 14;
  endfunction

  function automatic logic [15:0] edge_cap(input logic [7:0] a, input logic [7:0] b);
    logic [63:0] d;
    d = (a > b) ? 64'(a - b) : 64'(b - a);
    return 16'((64'(nscale_reg) * similarity(d * d * 64'(inv_reg))) >> 16);
  endfunction

  function automatic logic [63:0] minus_log_q12(input logic [7:0] v);
    logic [63:0] y, frac, total;
    int e;
    if (v == 8'd0) return 64'd56588;
    if (v == 8'd255) return 64'd0;
    e = 0;
    while ((64'(v) << (e + 1)) <= 64'd255) e++;
    y = (64'd255 << 30) / (64'(v) << e);
    frac = 64'd0;
    for (int i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac |= 64'd1 << (30 - i);
      end
    end
    total = (64'(e) << 30) | frac;
    return (total * 64'd744261118 + (64'd1 << 47)) >> 48;
  endfunction

  function automatic logic [11:0] terminal(input logic [7:0] v);
    logic [63:0] c;
    c = (64'(tscale_reg) * minus_log_q12(v) + (64'd1 << 19)) >> 20;
    if (c == 0 && tscale_reg != 0) c = 64'd1;
    return 12'(c);
  endfunction

  function automatic cap_word_t make_word(input int unsigned r, input int unsigned c,
      input logic [15:0] n, input logic [15:0] s, input logic [15:0] w,
      input logic [15:0] e, input logic [7:0] center, input logic eoi);
    cap_word_t o;
    o.row = 10'(r);
    o.col = 10'(c);
    o.north = n;
    o.south = s;
    o.west = w;
    o.east = e;
    o.source = terminal(8'd255 - center);
    o.sink = terminal(center);
    o.last_of_run = 1'b0;
    o.end_of_image = eoi;
    return o;
  endfunction

  function automatic int unsigned clamp_dim(input logic [10:0] v);
    if (v == 0) return 1;
    return (v > 1024) ? 1024 : int'(v);
  endfunction

  // capacities this pixel completes, appended to pending_caps
  function automatic void predict_caps(input logic [7:0] x);
    int unsigned w, h, r, c;
    cap_word_t run [$];
    logic [7:0] ctr;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    r = row_cnt;
    c = col_cnt;
    if (r >= 1) begin
      ctr = newer_line[c];
      run.push_back(make_word(r - 1, c,
        (r >= 2) ? edge_cap(ctr, older_line[c]) : 16'd0,
        edge_cap(ctr, x),
        (c >= 1) ? edge_cap(ctr, older_line[c - 1]) : 16'd0,
        (c + 1 < w) ? edge_cap(ctr, newer_line[c + 1]) : 16'd0, ctr, 1'b0));
    end
    if (r == h - 1 && c >= 1)
      run.push_back(make_word(r, c - 1,
        (r >= 1) ? edge_cap(prev_pix, older_line[c - 1]) : 16'd0, 16'd0,
        (c >= 2) ? edge_cap(prev_pix, newer_line[c - 2]) : 16'd0,
        edge_cap(prev_pix, x), prev_pix, 1'b0));
    older_line[c] = newer_line[c];
    newer_line[c] = x;
    if (r == h - 1 && c == w - 1)
      run.push_back(make_word(r, c,
        (r >= 1) ? edge_cap(x, older_line[c]) : 16'd0, 16'd0,
        (c >= 1) ? edge_cap(x, prev_pix) : 16'd0, 16'd0, x, 1'b1));
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) pending_caps.push_back(run[i]);
    prev_pix = x;
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // ---------------- drivers ----------------

  // APB write, called at a falling edge; also updates the predictor's registers
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = value[10:0];
      REG_HEIGHT: height_reg = value[10:0];
      REG_NSCALE: nscale_reg = value[15:0];
      REG_INV2S2: inv_reg = value;
      REG_TSCALE: tscale_reg = value[15:0];
      default: ;
    endcase
    if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
      row_cnt = 0;
      col_cnt = 0;
      prev_pix = 8'd0;
    end
  endtask

  // one pixel word; entered and left at a falling edge, valid left high
  task automatic send_pixel(input logic [7:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    intensity_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    predict_caps(x);
    @(negedge clk_i);
  endtask

  // wait for every expected word, then let any result-free pixel finish
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_caps.size() != 0) @(negedge clk_i);
    repeat (1500) @(negedge clk_i);
  endtask

  task automatic set_dims(input logic [31:0] w, input logic [31:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic send_frame(input int unsigned pixels, input int unsigned top);
    for (int unsigned i = 0; i < pixels; i++) send_pixel(8'($urandom_range(top)));
  endtask

  // ---------------- checker ----------------

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_caps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cap word %p", got);
      end else begin
        if (got !== pending_caps[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cap word mismatch\n  expected %p\n  actual   %p", pending_caps[0], got);
        end
        void'(pending_caps.pop_front());
      end
    end
  end

  // ---------------- tests ----------------

  // single pixel frame, zero and oversize dimensions, partial frames restarted
  task automatic test_dimensions();
    set_dims(1, 1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();
    set_dims(0, 0);
    send_pixel(8'd128);
    drain();
    // oversize width on a one-row frame: only a few pixels, then restart
    set_dims(32'h7FF, 1);
    send_frame(4, 255);
    drain();
    set_dims(2, 32'h7FF);
    send_frame(6, 255);
    drain();
  endtask

  // intensity extremes with all-zero and all-max gains
  task automatic test_gain_extremes();
    write_reg(REG_NSCALE, 32'hFFFF);
    write_reg(REG_INV2S2, 32'd0);
    write_reg(REG_TSCALE, 32'hFFFF);
    set_dims(3, 2);
    send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd1);
    send_pixel(8'd254); send_pixel(8'd0);   send_pixel(8'd255);
    drain();
    write_reg(REG_NSCALE, 32'd0);
    write_reg(REG_INV2S2, 32'hFFFFFFFF);
    write_reg(REG_TSCALE, 32'd0);
    set_dims(2, 2);
    send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd7); send_pixel(8'd8);
    drain();
    // exponent near the cutoff of 16: k just below 16.0, d = 1 just under it and d = 2 above it
    write_reg(REG_NSCALE, 32'd40000);
    write_reg(REG_INV2S2, 32'h0FFF_FFFF);
    write_reg(REG_TSCALE, 32'd1);
    set_dims(2, 2);
    send_pixel(8'd10); send_pixel(8'd11); send_pixel(8'd11); send_pixel(8'd9);
    drain();
  endtask

  // random frames; most complete, some cut short by a dimension write
  task automatic test_random_frames();
    int unsigned w, h, n;
    while (rand_items < 180) begin
      if (rand_items < 60) begin
        send_idle_pct = 21; recv_stall_pct = 79;
      end else if (rand_items < 120) begin
        send_idle_pct = 79; recv_stall_pct = 21;
      end else begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      write_reg(REG_NSCALE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000));
      write_reg(REG_INV2S2, ($urandom_range(4) == 0) ? $urandom : $urandom_range(20000));
      write_reg(REG_TSCALE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(2048));
      w = ($urandom_range(5) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1);
      h = $urandom_range(4, 1);
      set_dims(w, h);
      n = w * h;
      if ($urandom_range(5) == 0) n = $urandom_range(n);
      // one frame in four uses a narrow grey range so similarities stay large
      send_frame(n, ($urandom_range(3) == 0) ? 12 : 255);
      rand_items += n;
      drain();
    end
  endtask

  initial begin
    width_reg = WidthRst;
    height_reg = HeightRst;
    nscale_reg = NScaleRst;
    inv_reg = Inv2S2Rst;
    tscale_reg = TScaleRst;
    row_cnt = 0;
    col_cnt = 0;
    prev_pix = 8'd0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 21;
    recv_stall_pct = 79;
    test_dimensions();
    test_gain_extremes();
    test_random_frames();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
